[hw/rtl/text_encoding_to_utf8_transcoder_top_assert.svh]
// ----------------------------------------------------------------------------
// Transcoder assertion macros
// Concurrent check macros used by the transcoder top level
// ----------------------------------------------------------------------------
`ifndef TEXT_ENCODING_TO_UTF8_TRANSCODER_TOP_ASSERT_SVH
`define TEXT_ENCODING_TO_UTF8_TRANSCODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TE2U8_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("transcoder check failed");

// next-cycle implication
`define TE2U8_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("transcoder check failed");

`else

`define TE2U8_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define TE2U8_ASSERT_NXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

[hw/rtl/te2u8_pkg.sv]
// ----------------------------------------------------------------------------
// Transcoder package
// Encoding codes, constants and shared types of the UTF-8 transcoder
// ----------------------------------------------------------------------------
`default_nettype none

package te2u8_pkg;

    // per-string mode
    localparam logic [2:0] MODE_LATIN1  = 3'd0;
    localparam logic [2:0] MODE_U16_BOM = 3'd1;
    localparam logic [2:0] MODE_U16_BE  = 3'd2;
    localparam logic [2:0] MODE_UTF8    = 3'd3;
    localparam logic [2:0] MODE_UNKNOWN = 3'd4;

    localparam logic [7:0]  ENC_MAX_KNOWN = 8'd3;
    localparam logic [7:0]  ENC_U16_BOM   = 8'd1;
    localparam logic [7:0]  ENC_U16_BE    = 8'd2;

    localparam logic [15:0] UNIT_BOM_SWAPPED = 16'hFFFE;
    localparam logic [15:0] UNIT_SUR_LO      = 16'hD800;
    localparam logic [15:0] UNIT_SUR_HI      = 16'hDFFF;
    localparam logic [20:0] CP_SUPP_BASE     = 21'h10000;
    localparam int          SUR_SHIFT        = 'hA;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [2:0] mode;
        logic       done_flag;
        logic       byte_pending;
        logic [7:0] held_byte;
        logic       order_mark_pending;
        logic       swap_bytes;
        logic       surrogate_pending;
        logic [9:0] high_bits;
    } st_t;

    localparam st_t ST_RESET = '{
        mode:               MODE_LATIN1,
        done_flag:          1'b1,
        byte_pending:       1'b0,
        held_byte:          8'h00,
        order_mark_pending: 1'b0,
        swap_bytes:         1'b0,
        surrogate_pending:  1'b0,
        high_bits:          10'h000
    };

    // result burst caused by one request
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            cnt;
        logic                        eos;
        logic                        err;
    } res_t;

endpackage

`default_nettype wire

[hw/rtl/te2u8_ifs.sv]
// ----------------------------------------------------------------------------
// Transcoder channel interfaces
// Valid/ready channels for raw string bytes and UTF-8 results
// ----------------------------------------------------------------------------
`default_nettype none

interface te2u8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_of_string;
    logic [7:0] encoding;
    logic       last_of_string;

    modport source (output valid, output in_byte, output first_of_string,
                    output encoding, output last_of_string, input ready);
    modport sink   (input valid, input in_byte, input first_of_string,
                    input encoding, input last_of_string, output ready);
endinterface

interface te2u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       error;
    logic       last;

    modport source (output valid, output out_byte, output end_of_string,
                    output error, output last, input ready);
    modport sink   (input valid, input out_byte, input end_of_string,
                    input error, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/te2u8_step.sv]
// ----------------------------------------------------------------------------
// Transcoder step logic
// Next string state and UTF-8 result burst for one input byte
// ----------------------------------------------------------------------------
`default_nettype none

module te2u8_step (
    input  wire logic [7:0]     in_byte,
    input  wire logic           first_of_string,
    input  wire logic [7:0]     encoding,
    input  wire logic           last_of_string,
    input  wire te2u8_pkg::st_t st,
    output te2u8_pkg::st_t      st_next,
    output te2u8_pkg::res_t     res
);
    import te2u8_pkg::*;

    st_t              ns;
    logic             term;
    logic             err;
    logic             enc_en;
    logic             raw_en;
    logic [20:0]      cp;
    logic [15:0]      unit;
    logic [CNT_W-1:0] n;
    logic [MAX_RESULTS-1:0][7:0] b;

    // state walk
    always_comb
    begin
        ns     = st;
        term   = 1'b0;
        err    = 1'b0;
        enc_en = 1'b0;
        raw_en = 1'b0;
        cp     = '0;
        unit   = '0;

        if (first_of_string)
        begin
            ns.mode               = (encoding <= ENC_MAX_KNOWN) ? encoding[2:0] : MODE_UNKNOWN;
            ns.done_flag          = 1'b0;
            ns.byte_pending       = 1'b0;
            ns.held_byte          = 8'h00;
            ns.order_mark_pending = (encoding == ENC_U16_BOM);
            ns.swap_bytes         = (encoding == ENC_U16_BE);
            ns.surrogate_pending  = 1'b0;
            ns.high_bits          = '0;
            if (encoding > ENC_MAX_KNOWN)
            begin
                term = 1'b1;
            end
        end

        if (!term && !ns.done_flag)
        begin
            case (ns.mode) inside
                MODE_LATIN1, MODE_UTF8:
                begin
                    if (in_byte == 8'h00)
                    begin
                        term = 1'b1;
                    end
                    else if (ns.mode == MODE_LATIN1)
                    begin
                        enc_en = 1'b1;
                        cp     = {13'b0, in_byte};
                    end
                    else
                    begin
                        raw_en = 1'b1;
                    end
                end
                MODE_U16_BOM, MODE_U16_BE:
                begin
                    if (!ns.byte_pending)
                    begin
                        ns.held_byte    = in_byte;
                        ns.byte_pending = 1'b1;
                    end
                    else
                    begin
                        unit = ns.swap_bytes ? {ns.held_byte, in_byte}
                                             : {in_byte, ns.held_byte};
                        ns.byte_pending = 1'b0;
                        if (ns.order_mark_pending)
                        begin
                            ns.order_mark_pending = 1'b0;
                            ns.swap_bytes         = (unit == UNIT_BOM_SWAPPED);
                            term                  = (unit == 16'h0000);
                        end
                        else if (ns.surrogate_pending)
                        begin
                            // low unit of the pair is taken as is
                            ns.surrogate_pending = 1'b0;
                            enc_en = 1'b1;
                            cp     = CP_SUPP_BASE
                                   + {1'b0, ns.high_bits, unit[9:0]};
                        end
                        else if (unit >= UNIT_SUR_LO && unit <= UNIT_SUR_HI)
                        begin
                            // unit minus the surrogate base keeps its low ten bits
                            ns.high_bits         = unit[SUR_SHIFT-1:0];
                            ns.surrogate_pending = 1'b1;
                        end
                        else if (unit == 16'h0000)
                        begin
                            term = 1'b1;
                        end
                        else
                        begin
                            enc_en = 1'b1;
                            cp     = {5'b0, unit};
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (!term && last_of_string)
            begin
                term = 1'b1;
                err  = ns.byte_pending | ns.surrogate_pending | ns.order_mark_pending;
            end
        end

        if (term)
        begin
            ns.done_flag = 1'b1;
        end
    end

    // utf-8 byte packing, terminator slot stays zero
    always_comb
    begin
        b = '0;
        n = '0;
        if (raw_en)
        begin
            b[0] = in_byte;
            n    = CNT_W'(1);
        end
        else if (enc_en)
        begin
            if (cp < 21'h80)
            begin
                b[0] = cp[7:0];
                n    = CNT_W'(1);
            end
            else if (cp < 21'h800)
            begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
                n    = CNT_W'(2);
            end
            else if (cp < 21'h10000)
            begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
                n    = CNT_W'(3);
            end
            else
            begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
                n    = CNT_W'(4);
            end
        end
    end

    assign st_next   = ns;
    assign res.bytes = b;
    assign res.cnt   = n + CNT_W'(term);
    assign res.eos   = term;
    assign res.err   = err;

endmodule

`default_nettype wire

[hw/rtl/text_encoding_to_utf8_transcoder_top.sv]
// ----------------------------------------------------------------------------
// Tag string to UTF-8 transcoder
// Turns Latin-1, UTF-16 (order mark or big-endian) and UTF-8 string bytes
// into UTF-8 bytes closed by a single zero terminator or error result
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   in_byte, first_of_string, encoding, last_of_string
//  out_ch    out  valid/ready   out_byte, end_of_string, error, last
//
//  a request is decoded in the cycle it is taken; its 0..5 result bytes leave
//  from a burst register at one byte per cycle while out_ch is ready
//  the next request is taken in the cycle the last byte of a burst is taken
//  rst_n clears string state (idle until a first byte) and drops any burst
//  out_ch stall holds the burst; in_ch sees ready low meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_encoding_to_utf8_transcoder_top_assert.svh"

module text_encoding_to_utf8_transcoder_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    te2u8_in_if.sink    in_ch,
    te2u8_out_if.source out_ch
);
    import te2u8_pkg::*;

    // string state, updated on every request
    st_t              st_reg;
    st_t              st_next;

    // result burst of the last request taken that produced bytes
    res_t             res_next;
    res_t             res_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] idx_reg;

    logic             in_fire;
    logic             out_fire;
    logic             out_last;
    logic             burst_done;

    te2u8_step u_step (
        .in_byte         (in_ch.in_byte),
        .first_of_string (in_ch.first_of_string),
        .encoding        (in_ch.encoding),
        .last_of_string  (in_ch.last_of_string),
        .st              (st_reg),
        .st_next         (st_next),
        .res             (res_next)
    );

    // burst position of the byte on the output
    assign out_last   = (idx_reg == res_reg.cnt - CNT_W'(1));
    assign out_fire   = out_ch.valid && out_ch.ready;
    assign burst_done = out_fire && out_last;

    // take a request when the burst register is free or frees this cycle
    assign in_ch.ready = !busy_reg || burst_done;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_RESET;
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                st_reg <= st_next;
            end

            if (in_fire && res_next.cnt != '0)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (burst_done)
            begin
                busy_reg <= 1'b0;
            end
            else if (out_fire)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    // burst payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire && res_next.cnt != '0)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid         = busy_reg;
    assign out_ch.out_byte      = res_reg.bytes[idx_reg];
    assign out_ch.last          = out_last;
    assign out_ch.end_of_string = out_last && res_reg.eos;
    assign out_ch.error         = out_last && res_reg.err;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // burst index stays inside the loaded burst
    `TE2U8_ASSERT_IMP(a_idx_in_burst, clk, rst_n, busy_reg, idx_reg < res_reg.cnt)

    // a closed string produces nothing until the next first byte
    `TE2U8_ASSERT_IMP(a_idle_silent, clk, rst_n,
        in_fire && st_reg.done_flag && !in_ch.first_of_string, res_next.cnt == '0)

    // an error result always closes its string
    `TE2U8_ASSERT_IMP(a_err_closes, clk, rst_n,
        out_ch.valid && out_ch.error, out_ch.end_of_string && out_ch.last)

    // closing a string leaves the state done
    `TE2U8_ASSERT_NXT(a_eos_done, clk, rst_n,
        in_fire && res_next.eos, st_reg.done_flag)

endmodule

`default_nettype wire

[tb/text_encoding_to_utf8_transcoder_top_tb.sv]
// ----------------------------------------------------------------------------
// Tag string to UTF-8 transcoder testbench
// Sends Latin-1, UTF-16 and UTF-8 tag strings, with broken and unknown ones
// mixed in, and checks every UTF-8 byte against a transcoding predictor
// ----------------------------------------------------------------------------
module text_encoding_to_utf8_transcoder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import te2u8_pkg::*;

    // encodings that the package has no name for
    localparam logic [7:0] ENC_LATIN1    = 8'd0;
    localparam logic [7:0] ENC_UTF8      = 8'd3;
    localparam logic [7:0] ENC_UNDEFINED = 8'd255;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int TARGET_ITEMS  = 240;
    localparam int QUIET_ITEMS   = 70;
    localparam int PRESSURE_ITEM = 130;

    // one UTF-8 output byte with its flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
        logic       error;
        logic       last;
    } utf8_res_t;

    // ------------------------------------------------------------------------
    // scoreboard: tracks the string state of the transcoder and keeps the
    // UTF-8 bytes that the accepted requests must produce, oldest first
    // ------------------------------------------------------------------------
    class utf8_scoreboard;
        logic [2:0] mode;
        logic       open;
        logic       byte_pending;
        logic [7:0] held;
        logic       bom_pending;
        logic       swap;
        logic       sur_pending;
        logic [9:0] high_bits;

        utf8_res_t utf8_expected_q[$];
        int n_requests;
        int n_strings;
        int n_bytes_checked;
        int n_trunc_errors;
        int n_fail;

        function new();
            mode = MODE_LATIN1;
            open = 1'b0;
            byte_pending = 1'b0;
            held = 8'h00;
            bom_pending = 1'b0;
            swap = 1'b0;
            sur_pending = 1'b0;
            high_bits = 10'h000;
            n_requests = 0;
            n_strings = 0;
            n_bytes_checked = 0;
            n_trunc_errors = 0;
            n_fail = 0;
        endfunction

        function void emit(logic [7:0] b, logic eos, logic err);
            utf8_expected_q.push_back('{b, eos, err, 1'b0});
        endfunction

        function void close_string(logic err);
            emit(8'h00, 1'b1, err);
            if (err)
                n_trunc_errors++;
            open = 1'b0;
        endfunction

        function void encode_cp(logic [20:0] cp);
            if (cp < 21'h80)
                emit(cp[7:0], 1'b0, 1'b0);
            else if (cp < 21'h800)
            begin
                emit({3'b110, cp[10:6]}, 1'b0, 1'b0);
                emit({2'b10, cp[5:0]}, 1'b0, 1'b0);
            end
            else if (cp < 21'h10000)
            begin
                emit({4'b1110, cp[15:12]}, 1'b0, 1'b0);
                emit({2'b10, cp[11:6]}, 1'b0, 1'b0);
                emit({2'b10, cp[5:0]}, 1'b0, 1'b0);
            end
            else
            begin
                emit({5'b11110, cp[20:18]}, 1'b0, 1'b0);
                emit({2'b10, cp[17:12]}, 1'b0, 1'b0);
                emit({2'b10, cp[11:6]}, 1'b0, 1'b0);
                emit({2'b10, cp[5:0]}, 1'b0, 1'b0);
            end
        endfunction

        function void note_request(logic [7:0] b, logic first, logic [7:0] enc,
                                   logic last_in);
            int        start;
            logic [15:0] unit;
            utf8_res_t tail;
            start = utf8_expected_q.size();
            n_requests++;
            if (first)
            begin
                mode = (enc <= ENC_MAX_KNOWN) ? enc[2:0] : MODE_UNKNOWN;
                open = 1'b1;
                byte_pending = 1'b0;
                held = 8'h00;
                bom_pending = (enc == ENC_U16_BOM);
                swap = (enc == ENC_U16_BE);
                sur_pending = 1'b0;
                high_bits = 10'h000;
                n_strings++;
                if (mode == MODE_UNKNOWN)
                    close_string(1'b0);
            end
            if (open)
            begin
                if (mode == MODE_LATIN1 || mode == MODE_UTF8)
                begin
                    if (b == 8'h00)
                        close_string(1'b0);
                    else if (mode == MODE_LATIN1)
                        encode_cp({13'd0, b});
                    else
                        emit(b, 1'b0, 1'b0);
                end
                else if (!byte_pending)
                begin
                    held = b;
                    byte_pending = 1'b1;
                end
                else
                begin
                    unit = swap ? {held, b} : {b, held};
                    byte_pending = 1'b0;
                    if (bom_pending)
                    begin
                        bom_pending = 1'b0;
                        swap = (unit == UNIT_BOM_SWAPPED);
                        if (unit == 16'h0000)
                            close_string(1'b0);
                    end
                    else if (sur_pending)
                    begin
                        sur_pending = 1'b0;
                        encode_cp(CP_SUPP_BASE + {high_bits, unit[9:0]});
                    end
                    else if (unit >= UNIT_SUR_LO && unit <= UNIT_SUR_HI)
                    begin
                        high_bits = 10'(unit - UNIT_SUR_LO);
                        sur_pending = 1'b1;
                    end
                    else if (unit == 16'h0000)
                        close_string(1'b0);
                    else
                        encode_cp({5'd0, unit});
                end
                if (open && last_in)
                    close_string(byte_pending | sur_pending | bom_pending);
            end
            if (utf8_expected_q.size() > start)
            begin
                tail = utf8_expected_q.pop_back();
                tail.last = 1'b1;
                utf8_expected_q.push_back(tail);
            end
        endfunction

        function void check_byte(utf8_res_t got);
            utf8_res_t want;
            if (utf8_expected_q.size() == 0)
            begin
                n_fail++;
                $display("%0t: unexpected byte %02h eos=%b err=%b last=%b", $time,
                         got.out_byte, got.end_of_string, got.error, got.last);
                return;
            end
            want = utf8_expected_q.pop_front();
            n_bytes_checked++;
            if (got.out_byte !== want.out_byte || got.end_of_string !== want.end_of_string
                || got.error !== want.error || got.last !== want.last)
            begin
                n_fail++;
                $display("%0t: expected byte %02h eos=%b err=%b last=%b, got %02h %b %b %b",
                         $time, want.out_byte, want.end_of_string, want.error, want.last,
                         got.out_byte, got.end_of_string, got.error, got.last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    // quiet turns off random idling on both sides; the long stall request
    // makes the receiver hold off while the sender keeps pushing
    logic quiet;
    logic long_stall_req;

    int cycles = 0;
    int items_sent = 0;
    logic [7:0] body_q[$];

    utf8_scoreboard sb = new();

    te2u8_in_if  in_ch();
    te2u8_out_if out_ch();

    text_encoding_to_utf8_transcoder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected", cycles,
                     sb.utf8_expected_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // monitor: requests are noted before results are checked; all values are
    // sampled as they stood before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_request(in_ch.in_byte, in_ch.first_of_string, in_ch.encoding,
                                in_ch.last_of_string);
            if (out_ch.valid && out_ch.ready)
                sb.check_byte('{out_ch.out_byte, out_ch.end_of_string, out_ch.error,
                                out_ch.last});
        end
    end

    // receiver: random back-pressure, plus one long hold-off counted here
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (long_stall_req && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
                out_ch.ready <= quiet || ($urandom_range(99) >= 32);
        end
    end

    // one request; valid stays high into the next call unless it idles first
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [7:0] enc,
                             input logic last_in);
        while (!quiet && $urandom_range(99) < 32)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.in_byte         <= b;
        in_ch.first_of_string <= first;
        // the encoding only counts on a first byte, so elsewhere it is noise
        in_ch.encoding        <= first ? enc : 8'($urandom);
        in_ch.last_of_string  <= last_in;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    function automatic void push_unit(logic [15:0] u, logic big_endian);
        if (big_endian)
        begin
            body_q.push_back(u[15:8]);
            body_q.push_back(u[7:0]);
        end
        else
        begin
            body_q.push_back(u[7:0]);
            body_q.push_back(u[15:8]);
        end
    endfunction

    function automatic logic [15:0] rand_bmp();
        case ($urandom_range(4))
            0: return 16'($urandom_range(1, 'h7F));
            1: return 16'($urandom_range('h80, 'h7FF));
            2: return 16'($urandom_range('h800, 'hD7FF));
            3: return 16'($urandom_range('hE000, 'hFFFF));
            default: return 16'($urandom_range(1, 'hFFFF));
        endcase
    endfunction

    // a mix of plain units, surrogate pairs, stray low halves and rare zeros
    function automatic void add_units(logic big_endian, int n);
        repeat (n)
        begin
            case ($urandom_range(9))
                5, 6:
                begin
                    push_unit(16'($urandom_range('hD800, 'hDBFF)), big_endian);
                    push_unit(16'($urandom_range('hDC00, 'hDFFF)), big_endian);
                end
                7:
                begin
                    push_unit(16'($urandom_range('hDC00, 'hDFFF)), big_endian);
                    push_unit(16'($urandom), big_endian);
                end
                8: push_unit(($urandom_range(3) == 0) ? 16'h0000 : rand_bmp(), big_endian);
                9: push_unit(16'($urandom), big_endian);
                default: push_unit(rand_bmp(), big_endian);
            endcase
        end
    endfunction

    // builds one string, maybe breaks it, sends it, and maybe adds stray bytes
    task automatic send_random_string();
        logic [7:0]  enc;
        logic [15:0] mark;
        logic        big_endian;
        int          n;
        int          kind;
        int          cut;
        bit          close_it;
        body_q.delete();
        n = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
        case ($urandom_range(19))
            0, 1, 2, 3, 4: enc = ENC_LATIN1;
            5, 6, 7, 8, 9: enc = ENC_U16_BOM;
            10, 11, 12, 13, 14: enc = ENC_U16_BE;
            15, 16, 17, 18: enc = ENC_UTF8;
            default: enc = 8'($urandom_range(4, 255));
        endcase
        if (enc == ENC_LATIN1 || enc == ENC_UTF8 || enc > ENC_MAX_KNOWN)
        begin
            repeat (n)
                body_q.push_back(8'($urandom_range(1, 255)));
            // a zero byte inside ends the string early
            if ($urandom_range(9) == 0)
            begin
                body_q.push_back(8'h00);
                body_q.push_back(8'($urandom));
            end
        end
        else if (enc == ENC_U16_BE)
            add_units(1'b1, n);
        else
        begin
            case ($urandom_range(7))
                0: mark = 16'($urandom);
                1, 2, 3, 4: mark = UNIT_BOM_SWAPPED;
                default: mark = 16'hFEFF;
            endcase
            // the mark is read low byte first
            push_unit(mark, 1'b0);
            add_units(mark == UNIT_BOM_SWAPPED, n);
        end

        // most strings are well formed; some are cut short or left open
        kind = $urandom_range(99);
        close_it = (kind >= 8);
        if (kind < 15 && body_q.size() > 1)
        begin
            cut = $urandom_range(1, body_q.size() - 1);
            repeat (cut)
                void'(body_q.pop_back());
        end

        for (int i = 0; i < body_q.size(); i++)
            send_byte(body_q[i], i == 0, enc, close_it && i == body_q.size() - 1);
        items_sent += body_q.size();

        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, ENC_LATIN1, 1'($urandom));
    endtask

    initial
    begin
        in_ch.valid           = 1'b0;
        in_ch.in_byte         = 8'h00;
        in_ch.first_of_string = 1'b0;
        in_ch.encoding        = 8'h00;
        in_ch.last_of_string  = 1'b0;
        rst_n                 = 1'b0;
        quiet                 = 1'b0;
        long_stall_req        = 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing is open right after reset, so this byte is dropped
        send_byte(8'h41, 1'b0, ENC_LATIN1, 1'b0);
        // latin-1: top value, last ascii value, first two-byte value
        send_byte(8'hFF, 1'b1, ENC_LATIN1, 1'b0);
        send_byte(8'h7F, 1'b0, ENC_LATIN1, 1'b0);
        send_byte(8'h80, 1'b0, ENC_LATIN1, 1'b1);
        // string already closed
        send_byte(8'h55, 1'b0, ENC_LATIN1, 1'b0);
        // unknown encoding gives the terminator alone and skips the rest
        send_byte(8'h00, 1'b1, ENC_UNDEFINED, 1'b0);
        send_byte(8'h12, 1'b0, ENC_LATIN1, 1'b1);
        // big-endian pair for the highest code point, then an odd byte count
        send_byte(8'hDB, 1'b1, ENC_U16_BE, 1'b0);
        send_byte(8'hFF, 1'b0, ENC_U16_BE, 1'b0);
        send_byte(8'hDF, 1'b0, ENC_U16_BE, 1'b0);
        send_byte(8'hFF, 1'b0, ENC_U16_BE, 1'b0);
        send_byte(8'h00, 1'b0, ENC_U16_BE, 1'b1);
        // swapped order mark selects big-endian; high half left open at the end
        send_byte(8'hFE, 1'b1, ENC_U16_BOM, 1'b0);
        send_byte(8'hFF, 1'b0, ENC_U16_BOM, 1'b0);
        send_byte(8'hD8, 1'b0, ENC_U16_BOM, 1'b0);
        send_byte(8'h00, 1'b0, ENC_U16_BOM, 1'b1);
        // a zero order mark ends the string at once
        send_byte(8'h00, 1'b1, ENC_U16_BOM, 1'b0);
        send_byte(8'h00, 1'b0, ENC_U16_BOM, 1'b0);
        // utf-8 string dropped by a restart into little-endian utf-16, where a
        // stray low half opens a pair: five bytes from the final request
        send_byte(8'hE2, 1'b1, ENC_UTF8, 1'b0);
        send_byte(8'hFF, 1'b1, ENC_U16_BOM, 1'b0);
        send_byte(8'hFE, 1'b0, ENC_U16_BOM, 1'b0);
        send_byte(8'h00, 1'b0, ENC_U16_BOM, 1'b0);
        send_byte(8'hDC, 1'b0, ENC_U16_BOM, 1'b0);
        send_byte(8'h41, 1'b0, ENC_U16_BOM, 1'b0);
        send_byte(8'h00, 1'b0, ENC_U16_BOM, 1'b1);

        // random strings: a quiet stretch first, one long receiver hold-off later
        quiet <= 1'b1;
        items_sent = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            if (items_sent >= QUIET_ITEMS)
                quiet <= 1'b0;
            if (items_sent >= PRESSURE_ITEM)
                long_stall_req <= 1'b1;
            send_random_string();
        end
        in_ch.valid <= 1'b0;

        while (sb.utf8_expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("sent %0d requests in %0d strings over %0d cycles", sb.n_requests,
                 sb.n_strings, cycles);
        $display("checked %0d utf-8 bytes, %0d strings closed by a truncation error",
                 sb.n_bytes_checked, sb.n_trunc_errors);
        if (sb.n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/te2u8_pkg.sv
hw/rtl/te2u8_ifs.sv
hw/rtl/te2u8_step.sv
hw/rtl/text_encoding_to_utf8_transcoder_top.sv
tb/text_encoding_to_utf8_transcoder_top_tb.sv
